FILE: design/aac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aac_pkg
// Types and constants shared by the ADC averaging and calibration block.
// ----------------------------------------------------------------------------
package aac_pkg;

    // configuration register indexes
    localparam logic [3:0] REG_RANGES     = 4'd0;
    localparam logic [3:0] REG_SAMPLES    = 4'd1;
    localparam logic [3:0] REG_REF_NUM    = 4'd2;
    localparam logic [3:0] REG_REF_DIV    = 4'd3;
    localparam logic [3:0] REG_OFF_NUM    = 4'd4;
    localparam logic [3:0] REG_OFF_DIV    = 4'd5;
    localparam logic [3:0] REG_GAIN_NUM   = 4'd6;
    localparam logic [3:0] REG_GAIN_DIV   = 4'd7;

    // range codes
    localparam logic [1:0] RANGE_10V      = 2'd0;
    localparam logic [1:0] RANGE_5V       = 2'd1;
    localparam logic [1:0] RANGE_2V5      = 2'd2;

    // 100 uV * range / (25 * range divisor), common factors removed
    localparam logic [15:0] SCALE_10V     = 16'd40000;
    localparam logic [15:0] SCALE_5V      = 16'd20000;
    localparam logic [15:0] SCALE_2V5     = 16'd10000;
    localparam logic [13:0] OFFSET_SCALE  = 14'd10000;
    localparam int          CODE_SHIFT    = 15;

    localparam logic [12:0] MAX_SAMPLES   = 13'd4096;
    localparam int          QUEUE_DEPTH   = 4;

    // shared divider: dividend and divisor widths
    localparam int          DIV_W         = 56;
    localparam int          DIVR_W        = 20;

    typedef struct packed {
        logic [31:0]        ranges;
        logic [15:0]        ref_num;
        logic [15:0]        ref_div;
        logic signed [20:0] off_num;
        logic [19:0]        off_div;
        logic signed [20:0] gain_num;
        logic [19:0]        gain_den;
    } aac_cfg_t;

    typedef struct packed {
        logic [3:0]         channel;
        logic signed [27:0] sum;
        logic [12:0]        count;
    } aac_job_t;

endpackage
`default_nettype wire

FILE: design/aac_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aac_front
// Per-channel accumulation; hands finished batches to the job queue.
// ----------------------------------------------------------------------------
module aac_front #(
    parameter int CHANNELS = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire [3:0]             channel,
    input  wire signed [15:0]     sample_code,
    input  wire [12:0]            target,
    output logic                  push_valid,
    input  wire                   push_ready,
    output aac_pkg::aac_job_t     push_job
);
    import aac_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [27:0] acc_mem [CHANNELS];
    logic [12:0]        cnt_mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;

    logic               busy_reg;
    logic               hit_reg;
    logic [3:0]         ch_reg;
    logic signed [15:0] code_reg;
    logic signed [27:0] acc_rd_reg;
    logic [12:0]        cnt_rd_reg;
    logic               vld_rd_reg;

    logic [CW-1:0]      idx_in;
    logic [CW-1:0]      idx;
    logic signed [27:0] sum_new;
    logic [12:0]        cnt_new;
    logic               done;
    logic               finish;

    assign idx_in  = CW'(channel);
    assign idx     = CW'(ch_reg);
    assign in_ready = !busy_reg;

    assign sum_new = (vld_rd_reg ? acc_rd_reg : 28'sd0) + 28'(code_reg);
    assign cnt_new = (vld_rd_reg ? cnt_rd_reg : 13'd0) + 13'd1;
    assign done    = cnt_new >= target;

    assign push_valid       = busy_reg && hit_reg && done;
    assign push_job.channel = ch_reg;
    assign push_job.sum     = sum_new;
    assign push_job.count   = target;
    assign finish = busy_reg && (!(hit_reg && done) || push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                busy_reg <= 1'b1;
                hit_reg  <= 32'(channel) < CHANNELS;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            if (finish && hit_reg)
            begin
                // a finished batch just drops its entry
                valid_reg[idx] <= !done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg     <= channel;
            code_reg   <= sample_code;
            acc_rd_reg <= acc_mem[idx_in];
            cnt_rd_reg <= cnt_mem[idx_in];
            vld_rd_reg <= valid_reg[idx_in];
        end
        if (finish && hit_reg && !done)
        begin
            acc_mem[idx] <= sum_new;
            cnt_mem[idx] <= cnt_new;
        end
    end

endmodule
`default_nettype wire

FILE: design/aac_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aac_queue
// Small job queue between accumulation and calibration.
// ----------------------------------------------------------------------------
module aac_queue #(
    parameter int DEPTH = 4
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push_valid,
    output logic                  push_ready,
    input  aac_pkg::aac_job_t     push_job,
    output logic                  pop_valid,
    input  wire                   pop_ready,
    output aac_pkg::aac_job_t     pop_job
);
    import aac_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    aac_job_t        mem [DEPTH];
    logic [AW-1:0]   wptr_reg;
    logic [AW-1:0]   rptr_reg;
    logic [NW-1:0]   count_reg;
    logic            push;
    logic            pop;

    assign push_ready = count_reg < NW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = mem[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("job queue overfilled");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == NW'(DEPTH)) |-> wptr_reg == rptr_reg)
        else $error("job queue pointers disagree with fill count");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("job queue count missed a push");
`endif

endmodule
`default_nettype wire

FILE: design/aac_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aac_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aac_divider (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire [aac_pkg::DIV_W-1:0]   dividend,
    input  wire [aac_pkg::DIVR_W-1:0]  divisor,
    output logic                       done,
    output logic [aac_pkg::DIV_W-1:0]  quotient
);
    import aac_pkg::*;

    localparam int CNTW = $clog2(DIV_W + 1);

    logic [CNTW-1:0]   cnt_reg;
    logic [DIVR_W:0]   rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic              done_reg;
    logic [DIVR_W:0]   shifted;
    logic              fits;

    assign shifted  = {rem_reg[DIVR_W-1:0], quo_reg[DIV_W-1]};
    assign fits     = shifted >= {1'b0, divisor};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cnt_reg == CNTW'(1);
            if (start)
            begin
                cnt_reg <= CNTW'(DIV_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? shifted - {1'b0, divisor} : shifted;
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

FILE: design/aac_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aac_back
// Calibration sequencer: average, reference scaling, offset, gain, saturate.
// ----------------------------------------------------------------------------
module aac_back (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        job_valid,
    output logic                       job_ready,
    input  aac_pkg::aac_job_t          job,
    input  aac_pkg::aac_cfg_t          cfg,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [3:0]                 result_channel,
    output logic signed [31:0]         voltage,
    output logic                       div_start,
    output logic [aac_pkg::DIV_W-1:0]  div_dividend,
    output logic [aac_pkg::DIVR_W-1:0] div_divisor,
    input  wire                        div_done,
    input  wire [aac_pkg::DIV_W-1:0]   div_quotient
);
    import aac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_AVG, S_MREF, S_MSCALE, S_DREF_GO, S_DREF, S_MOFF, S_DOFF_GO,
        S_DOFF, S_MGLO, S_MGHI, S_DGAIN_GO, S_DGAIN, S_OUT
    } state_t;

    state_t              state_reg;
    logic                neg_reg;
    logic [3:0]          ch_reg;
    logic [16:0]         avg_reg;
    logic [DIV_W-1:0]    prod_reg;
    logic signed [35:0]  v_reg;
    logic                start_reg;
    logic [DIV_W-1:0]    dividend_reg;
    logic [DIVR_W-1:0]   divisor_reg;
    logic                out_valid_reg;
    logic signed [31:0]  voltage_reg;

    logic [1:0]          range_code;
    logic [15:0]         scale;
    logic [34:0]         v_mag;
    logic [20:0]         g_mag;
    logic [20:0]         o_mag;
    logic [27:0]         sum_mag;
    logic signed [35:0]  off_val;

    assign range_code = cfg.ranges[{ch_reg, 1'b0} +: 2];
    assign v_mag   = v_reg[35] ? 35'(-v_reg) : 35'(v_reg);
    assign g_mag   = cfg.gain_num[20] ? 21'(-cfg.gain_num) : 21'(cfg.gain_num);
    assign o_mag   = cfg.off_num[20] ? 21'(-cfg.off_num) : 21'(cfg.off_num);
    assign sum_mag = job.sum[27] ? 28'(-job.sum) : 28'(job.sum);
    assign off_val = neg_reg ? -36'(div_quotient[34:0]) : 36'(div_quotient[34:0]);

    always_comb
    begin
        unique case (range_code)
            RANGE_5V:  scale = SCALE_5V;
            RANGE_2V5: scale = SCALE_2V5;
            default:   scale = SCALE_10V;
        endcase
    end

    assign job_ready      = state_reg == S_IDLE;
    assign div_start      = start_reg;
    assign div_dividend   = dividend_reg;
    assign div_divisor    = divisor_reg;
    assign out_valid      = out_valid_reg;
    assign voltage        = voltage_reg;
    assign result_channel = ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        ch_reg       <= job.channel;
                        neg_reg      <= job.sum[27];
                        dividend_reg <= DIV_W'(sum_mag);
                        divisor_reg  <= DIVR_W'(job.count);
                        start_reg    <= 1'b1;
                        state_reg    <= S_AVG;
                    end
                end
                S_AVG:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= div_quotient[16:0];
                        state_reg <= S_MREF;
                    end
                end
                S_MREF:
                begin
                    prod_reg  <= DIV_W'(avg_reg * cfg.ref_num);
                    state_reg <= S_MSCALE;
                end
                S_MSCALE:
                begin
                    prod_reg  <= DIV_W'(prod_reg[32:0] * scale);
                    state_reg <= S_DREF_GO;
                end
                S_DREF_GO:
                begin
                    // divide by 32768 first, then by the reference divisor
                    dividend_reg <= prod_reg >> CODE_SHIFT;
                    divisor_reg  <= (cfg.ref_div == '0) ? DIVR_W'(1) : DIVR_W'(cfg.ref_div);
                    start_reg    <= 1'b1;
                    state_reg    <= S_DREF;
                end
                S_DREF:
                begin
                    if (div_done)
                    begin
                        v_reg     <= neg_reg ? -36'(div_quotient[34:0])
                                             : 36'(div_quotient[34:0]);
                        state_reg <= S_MOFF;
                    end
                end
                S_MOFF:
                begin
                    prod_reg  <= DIV_W'(o_mag * OFFSET_SCALE);
                    neg_reg   <= cfg.off_num[20];
                    state_reg <= S_DOFF_GO;
                end
                S_DOFF_GO:
                begin
                    dividend_reg <= prod_reg;
                    divisor_reg  <= (cfg.off_div == '0) ? DIVR_W'(1) : cfg.off_div;
                    start_reg    <= 1'b1;
                    state_reg    <= S_DOFF;
                end
                S_DOFF:
                begin
                    if (div_done)
                    begin
                        v_reg     <= v_reg + off_val;
                        state_reg <= S_MGLO;
                    end
                end
                S_MGLO:
                begin
                    // gain product in two partial products
                    prod_reg  <= DIV_W'(v_mag[17:0] * g_mag);
                    neg_reg   <= v_reg[35] ^ cfg.gain_num[20];
                    state_reg <= S_MGHI;
                end
                S_MGHI:
                begin
                    prod_reg  <= prod_reg + (DIV_W'(v_mag[34:18] * g_mag) << 18);
                    state_reg <= S_DGAIN_GO;
                end
                S_DGAIN_GO:
                begin
                    dividend_reg <= prod_reg;
                    divisor_reg  <= (cfg.gain_den == '0) ? DIVR_W'(1) : cfg.gain_den;
                    start_reg    <= 1'b1;
                    state_reg    <= S_DGAIN;
                end
                S_DGAIN:
                begin
                    if (div_done)
                    begin
                        if (neg_reg)
                        begin
                            voltage_reg <= (div_quotient > DIV_W'(32'h8000_0000))
                                ? 32'sh8000_0000 : -$signed(div_quotient[31:0]);
                        end
                        else
                        begin
                            voltage_reg <= (div_quotient > DIV_W'(32'h7fff_ffff))
                                ? 32'sh7fff_ffff : $signed(div_quotient[31:0]);
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: design/adc_average_calibrate_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_average_calibrate_unit
// Per-channel ADC averaging with reference, offset and gain calibration.
// ----------------------------------------------------------------------------
// The front end reads the channel's sum and count from the accumulator
// memory when it takes an ADC code, and writes them back before it takes
// the next one. When a channel reaches its sample count the batch moves into a
// four-entry job queue and the front end carries on. Calibration runs one
// batch at a time through a single shared bit-serial divider: four divisions
// of 56 quotient bits each, with control states between them.
// The front end also stalls while a finished batch waits on a full queue.
module adc_average_calibrate_unit #(
    parameter int CHANNELS = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_write,
    input  wire [3:0]          cfg_index,
    input  wire [31:0]         cfg_data,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire [3:0]          channel,
    input  wire signed [15:0]  sample_code,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [3:0]         result_channel,
    output logic signed [31:0] voltage
);
    import aac_pkg::*;

    aac_cfg_t          cfg_reg;
    logic [12:0]       samples_reg;
    logic [12:0]       target;

    logic              push_valid;
    logic              push_ready;
    aac_job_t          push_job;
    logic              pop_valid;
    logic              pop_ready;
    aac_job_t          pop_job;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIVR_W-1:0] div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ranges   <= '0;
            samples_reg      <= 13'd128;
            cfg_reg.ref_num  <= 16'd25;
            cfg_reg.ref_div  <= 16'd10;
            cfg_reg.off_num  <= '0;
            cfg_reg.off_div  <= 20'd1;
            cfg_reg.gain_num <= 21'sd1;
            cfg_reg.gain_den <= 20'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RANGES:   cfg_reg.ranges   <= cfg_data;
                REG_SAMPLES:  samples_reg      <= cfg_data[12:0];
                REG_REF_NUM:  cfg_reg.ref_num  <= cfg_data[15:0];
                REG_REF_DIV:  cfg_reg.ref_div  <= cfg_data[15:0];
                REG_OFF_NUM:  cfg_reg.off_num  <= cfg_data[20:0];
                REG_OFF_DIV:  cfg_reg.off_div  <= cfg_data[19:0];
                REG_GAIN_NUM: cfg_reg.gain_num <= cfg_data[20:0];
                REG_GAIN_DIV: cfg_reg.gain_den <= cfg_data[19:0];
                default:      ;
            endcase
        end
    end

    // zero means one, anything above 4096 clamps
    always_comb
    begin
        priority if (samples_reg == '0)
            target = 13'd1;
        else if (samples_reg > MAX_SAMPLES)
            target = MAX_SAMPLES;
        else
            target = samples_reg;
    end

    aac_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .sample_code (sample_code),
        .target      (target),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    aac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    aac_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (pop_valid),
        .job_ready      (pop_ready),
        .job            (pop_job),
        .cfg            (cfg_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_channel (result_channel),
        .voltage        (voltage),
        .div_start      (div_start),
        .div_dividend   (div_dividend),
        .div_divisor    (div_divisor),
        .div_done       (div_done),
        .div_quotient   (div_quotient)
    );

    aac_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

endmodule
`default_nettype wire
